// File: hw/rtl/fln_pkg.sv
// Shared types and constants for the float32 natural log pipeline.
package fln_pkg;

  // Long division u = floor(num * 2^62 / den), two quotient bits per stage.
  localparam int NumW      = 24;
  localparam int DenW      = 26;
  localparam int RemW      = 27;
  localparam int QuoW      = 62;
  localparam int DivBits   = 2;
  localparam int DivStages = QuoW / DivBits;

  // Series: ten Horner steps, plus u*u in front and u*q behind.
  localparam int HornerSteps = 10;
  localparam int MulCount    = HornerSteps + 2;

  // Back end: ln2 scaling, add, magnitude, two-level msb search, shift, round.
  localparam int TailStages = 7;
  localparam int PipeDepth  = 1 + DivStages + 2 * MulCount + TailStages;

  localparam logic [22:0] SqrtMant = 23'h3504F3;
  localparam logic [63:0] Ln2Q64   = 64'hB17217F7D1CF79AC;

  // floor(2^62 / (2k+1)), k = 0..10
  localparam logic [63:0] Coef [0:HornerSteps] = '{
    64'h4000000000000000,
    64'h1555555555555555,
    64'h0CCCCCCCCCCCCCCC,
    64'h0924924924924924,
    64'h071C71C71C71C71C,
    64'h05D1745D1745D174,
    64'h04EC4EC4EC4EC4EC,
    64'h0444444444444444,
    64'h03C3C3C3C3C3C3C3,
    64'h035E50D79435E50D,
    64'h030C30C30C30C30C
  };

  typedef struct packed {
    logic       uneg;   // r below one, ln r negative
    logic       eneg;   // exponent negative
    logic [7:0] eabs;   // |e|
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [63:0] u;
    logic [63:0] p;
  } hpass_t;

endpackage

// File: hw/rtl/fln_div.sv
// Pipelined restoring divider giving the Q62 quotient for u.
module fln_div import fln_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  side_t           side_i,
  output logic            valid_o,
  output logic [QuoW-1:0] quo_o,
  output side_t           side_o
);

  logic            valid_q [DivStages];
  logic [RemW-1:0] rem_q   [DivStages];
  logic [QuoW-1:0] quo_q   [DivStages];
  logic [DenW-1:0] den_q   [DivStages];
  side_t           side_q  [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic            vin;
    logic [RemW-1:0] rem_in, rem_d;
    logic [QuoW-1:0] quo_in, quo_d;
    logic [DenW-1:0] den_in;
    side_t           side_in;

    if (s == 0) begin : g_first
      assign vin     = valid_i;
      assign rem_in  = RemW'(num_i);
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vin     = valid_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      for (int b = 0; b < DivBits; b++) begin
        rem_d = {rem_d[RemW-2:0], 1'b0};
        if (rem_d >= RemW'(den_in)) begin
          rem_d = rem_d - RemW'(den_in);
          quo_d = {quo_d[QuoW-2:0], 1'b1};
        end else begin
          quo_d = {quo_d[QuoW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        quo_q[s]  <= quo_d;
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[DivStages-1];
  assign quo_o   = quo_q[DivStages-1];
  assign side_o  = side_q[DivStages-1];

  // |r-1|/(r+1) stays under 0.18, so u never reaches 2^60
  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (quo_o[QuoW-1:QuoW-2] == 2'b00))
    else $error("divider quotient out of range");

endmodule

// File: hw/rtl/fln_mul.sv
// Two-stage Q62 multiply-add: floor(a*b / 2^62) + c from four 32x32 partial products.
module fln_mul import fln_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic [63:0] c_i,
  input  hpass_t      pass_i,
  output logic        valid_o,
  output logic [63:0] res_o,
  output hpass_t      pass_o
);

  logic [63:0]  ll_d, lh_d, hl_d, hh_d;
  logic [63:0]  ll_q, lh_q, hl_q, hh_q, c_q;
  logic         v1_q, v2_q;
  hpass_t       pass1_q, pass2_q;
  logic [127:0] sum;
  logic [63:0]  res_d, res_q;

  assign ll_d = a_i[31:0]  * b_i[31:0];
  assign lh_d = a_i[31:0]  * b_i[63:32];
  assign hl_d = a_i[63:32] * b_i[31:0];
  assign hh_d = a_i[63:32] * b_i[63:32];

  assign sum   = {hh_q, 64'd0} + {32'd0, lh_q, 32'd0} + {32'd0, hl_q, 32'd0}
               + {64'd0, ll_q};
  assign res_d = sum[125:62] + c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q    <= ll_d;
      lh_q    <= lh_d;
      hl_q    <= hl_d;
      hh_q    <= hh_d;
      c_q     <= c_i;
      pass1_q <= pass_i;
      res_q   <= res_d;
      pass2_q <= pass1_q;
    end
  end

  assign valid_o = v2_q;
  assign res_o   = res_q;
  assign pass_o  = pass2_q;

  // every series value stays below 2.0 in Q62
  a_res_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !res_o[63])
    else $error("series value overflowed Q2.62");

endmodule

// File: hw/rtl/float32_natural_log.sv
// Top level: pipelined ln|x| for IEEE single bit patterns.
//
//   port group | dir | tdata bits (low to high)     | tuser/tlast
//   s_axis     | in  | [31:0] x_bits                | none
//   m_axis     | out | [31:0] log_bits              | none
//
// One beat enters per cycle while the output is not held. The pipe is a
// front-end register stage, the 31-stage divider (two quotient bits a stage),
// twelve two-stage multiply-adds for the series, and seven back-end stages for
// the ln2 term, add, magnitude, msb search, shift and rounding. All stages move
// on one enable: when a result sits unaccepted at the output the whole pipe
// holds, bubbles included. Reset clears valid bits and the in-flight check
// counter only.
module float32_natural_log import fln_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] x_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] log_bits
);

  logic en;

  // ---------------- front end: split exponent and mantissa ----------------
  logic [22:0]     frac;
  logic            big;
  logic [24:0]     rr;
  logic [9:0]      e10;
  logic [NumW-1:0] num_d, num_q;
  logic [DenW-1:0] den_d, den_q;
  side_t           side_d, side_q;
  logic            v0_q;

  assign frac  = s_axis_tdata[22:0];
  assign big   = frac > SqrtMant;                        // r above sqrt2: halve
  assign rr    = big ? {2'b01, frac} : {1'b1, frac, 1'b0};
  assign e10   = 10'(s_axis_tdata[30:23]) - 10'd127 + 10'(big);
  assign num_d = rr[24] ? rr[23:0] : NumW'(25'h1000000 - rr);
  assign den_d = DenW'(rr) + DenW'(26'h1000000);

  always_comb begin
    side_d.uneg = ~rr[24];
    side_d.eneg = e10[9];
    side_d.eabs = e10[9] ? 8'(-e10) : e10[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q  <= num_d;
      den_q  <= den_d;
      side_q <= side_d;
    end
  end

  // ---------------- u = |r-1| / (r+1) ----------------
  logic            dv;
  logic [QuoW-1:0] quo;
  side_t           dside;

  fln_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v0_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .side_i  (side_q),
    .valid_o (dv),
    .quo_o   (quo),
    .side_o  (dside)
  );

  // ---------------- series by Horner ----------------
  // step 0: p = u*u; steps 1..10: q = p*q + 1/(2k+1); step 11: u*q
  logic        h_valid [0:MulCount];
  hpass_t      h_pass  [0:MulCount];
  logic [63:0] h_q     [1:MulCount];

  assign h_valid[0] = dv;
  assign h_pass[0]  = '{side: dside, u: 64'(quo), p: 64'd0};

  for (genvar j = 0; j < MulCount; j++) begin : g_horner
    logic [63:0] a, b, c, mres;
    logic        mv;
    hpass_t      mpass;

    if (j == 0) begin : g_sq
      assign a = h_pass[0].u;
      assign b = h_pass[0].u;
      assign c = 64'd0;
      assign h_valid[1] = mv;
      assign h_pass[1]  = '{side: mpass.side, u: mpass.u, p: mres};
      assign h_q[1]     = Coef[HornerSteps];
    end else if (j == MulCount - 1) begin : g_last
      assign a = h_pass[j].u;
      assign b = h_q[j];
      assign c = 64'd0;
      assign h_valid[j+1] = mv;
      assign h_pass[j+1]  = mpass;
      assign h_q[j+1]     = mres;
    end else begin : g_step
      assign a = h_pass[j].p;
      assign b = h_q[j];
      assign c = Coef[HornerSteps-j];
      assign h_valid[j+1] = mv;
      assign h_pass[j+1]  = mpass;
      assign h_q[j+1]     = mres;
    end

    fln_mul u_mul (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (h_valid[j]),
      .a_i     (a),
      .b_i     (b),
      .c_i     (c),
      .pass_i  (h_pass[j]),
      .valid_o (mv),
      .res_o   (mres),
      .pass_o  (mpass)
    );
  end

  // ---------------- back end ----------------
  // T1: |e|*ln2 in Q8.56, ln r magnitude in Q8.56
  logic [71:0] eprod;
  logic [63:0] elog_q, lmag_q;
  logic        uneg1_q, eneg1_q, v1_q;

  assign eprod = Ln2Q64 * h_pass[MulCount].side.eabs;

  // T2: signed sum
  logic [63:0] s2_q;
  logic        v2_q;
  logic [63:0] t_term, l_term;

  assign t_term = eneg1_q ? -elog_q : elog_q;
  assign l_term = uneg1_q ? -lmag_q : lmag_q;

  // T3: sign and magnitude
  logic [63:0] mag3_q;
  logic        sign3_q, v3_q;

  // T4: per-16-bit group msb
  logic [3:0]  any_d, any4_q;
  logic [3:0]  idx_d [4];
  logic [3:0]  idx4_q [4];
  logic [63:0] mag4_q;
  logic        sign4_q, v4_q;

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      any_d[g] = |mag3_q[16*g +: 16];
      idx_d[g] = 4'd0;
      for (int k = 0; k < 16; k++) begin
        if (mag3_q[16*g + k]) idx_d[g] = 4'(k);
      end
    end
  end

  // T5: msb position
  logic [5:0]  m_d, m5_q;
  logic        zero5_q, sign5_q, v5_q;
  logic [63:0] mag5_q;

  always_comb begin
    m_d = '0;
    for (int g = 0; g < 4; g++) begin
      if (any4_q[g]) m_d = {2'(g), idx4_q[g]};
    end
  end

  // T6: normalise so the msb lands on bit 63
  logic [63:0] norm6_q;
  logic [5:0]  m6_q;
  logic        zero6_q, sign6_q, v6_q;

  // T7: round to nearest even and pack
  logic [23:0] keep;
  logic        inc;
  logic [24:0] kp;
  logic [7:0]  bexp;
  logic [22:0] mant;
  logic [31:0] log_d, log_q;
  logic        v7_q;

  assign keep = norm6_q[63:40];
  assign inc  = norm6_q[39] & ((|norm6_q[38:0]) | keep[0]);
  assign kp   = {1'b0, keep} + 25'(inc);
  assign bexp = 8'(m6_q) + 8'd71 + 8'(kp[24]);
  assign mant = kp[24] ? kp[23:1] : kp[22:0];
  assign log_d = zero6_q ? 32'd0 : {sign6_q, bexp, mant};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en) begin
      v1_q <= h_valid[MulCount];
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      elog_q  <= eprod[71:8];
      lmag_q  <= {6'd0, h_q[MulCount][62:5]};   // (2*u*q) >> 6, |ln r| in Q8.56
      uneg1_q <= h_pass[MulCount].side.uneg;
      eneg1_q <= h_pass[MulCount].side.eneg;
      s2_q    <= t_term + l_term;
      sign3_q <= s2_q[63];
      mag3_q  <= s2_q[63] ? -s2_q : s2_q;
      any4_q  <= any_d;
      idx4_q  <= idx_d;
      mag4_q  <= mag3_q;
      sign4_q <= sign3_q;
      m5_q    <= m_d;
      zero5_q <= ~|any4_q;
      mag5_q  <= mag4_q;
      sign5_q <= sign4_q;
      norm6_q <= mag5_q << (~m5_q);
      m6_q    <= m5_q;
      zero6_q <= zero5_q;
      sign6_q <= sign5_q;
      log_q   <= log_d;
    end
  end

  // ---------------- handshake ----------------
  assign en            = ~v7_q | m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v7_q;
  assign m_axis_tdata  = log_q;

  // beats in flight, kept for checking only
  localparam int CntW = $clog2(PipeDepth + 1);
  logic [CntW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + CntW'(s_axis_tvalid & s_axis_tready)
                     - CntW'(m_axis_tvalid & m_axis_tready);
    end
  end

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(PipeDepth))
    else $error("more beats in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !m_axis_tvalid)
    else $error("result presented with no beat in flight");

  a_msb_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && !zero5_q) |-> mag5_q[m5_q])
    else $error("msb search missed the leading one");

endmodule

// File: tb/sv/float32_natural_log_tb.sv
// Testbench for float32_natural_log: directed and random beats checked against a bit-exact predictor.
module float32_natural_log_tb import fln_pkg::*;;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;    // [31:0] x_bits
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [31:0] log_bits

  logic [31:0] log_queue [$];
  int          fail_count = 0;
  longint      cycle_count = 0;
  bit          sink_idle_en = 1'b1;

  localparam longint CycleLimit = 2000000;

  float32_natural_log u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  // 64x64 -> 128 product, keep bits [125:62]
  function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = a * b;
    return prod[125:62];
  endfunction

  function automatic logic [31:0] round_single(logic [63:0] s);
    logic        sgn;
    logic [63:0] mag, rem, half, keep;
    int          msb, sh;
    sgn = s[63];
    mag = sgn ? -s : s;
    if (mag == 0) return 32'h0;
    msb = 63;
    while (!mag[msb]) msb--;
    if (msb >= 24) begin
      sh   = msb - 23;
      rem  = mag & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      keep = mag >> sh;
      if (rem > half || (rem == half && keep[0])) keep++;
      if (keep[24]) begin
        keep = keep >> 1;
        msb++;
      end
    end else begin
      keep = mag << (23 - msb);
    end
    return {sgn, 8'(msb - 56 + 127), keep[22:0]};
  endfunction

  function automatic logic [31:0] natural_log(logic [31:0] x);
    logic [22:0]  frac;
    int           e;
    logic [63:0]  rr, num, den, u, p, q, lnr, elog, t, l;
    logic [127:0] wide;
    logic         uneg, eneg;
    frac = x[22:0];
    e    = int'(x[30:23]) - 127;
    if (frac > SqrtMant) begin
      rr = {40'd0, 1'b1, frac};
      e  = e + 1;
    end else begin
      rr = {39'd0, 1'b1, frac, 1'b0};
    end
    uneg = rr < (64'd1 << 24);
    num  = uneg ? (64'd1 << 24) - rr : rr - (64'd1 << 24);
    den  = rr + (64'd1 << 24);
    wide = ({64'd0, num} << 62) / {64'd0, den};
    u    = wide[63:0];
    p    = q62_mul(u, u);
    q    = Coef[10];
    for (int k = 9; k >= 0; k--) q = q62_mul(p, q) + Coef[k];
    lnr  = q62_mul(u, q) << 1;
    eneg = e < 0;
    wide = Ln2Q64 * 128'(eneg ? -e : e);
    elog = wide[71:8];
    t    = eneg ? -elog : elog;
    l    = lnr >> 6;
    l    = uneg ? -l : l;
    return round_single(t + l);
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    fail_count++;
  endtask

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
  endfunction

  task automatic send_beat(logic [31:0] x, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    do @(posedge clk_i); while (!s_axis_tready);
    log_queue.push_back(natural_log(x));
    @(negedge clk_i);
  endtask

  task automatic finish_stream();
    s_axis_tvalid <= 1'b0;
  endtask

  // result side: stall the sink at random
  initial begin
    int g;
    forever begin
      @(negedge clk_i);
      g = 0;
      if (sink_idle_en && $urandom_range(0, 3) == 0) g = gap_len();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (log_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h", m_axis_tdata));
      end else begin
        if (m_axis_tdata !== log_queue[0])
          report_mismatch($sformatf("log_bits got %h want %h", m_axis_tdata, log_queue[0]));
        void'(log_queue.pop_front());
      end
    end
  end

  task automatic test_directed();
    logic [31:0] pats [$];
    pats = '{32'h3F800000, 32'hBF800000, 32'h00000000, 32'h80000000, 32'h00000001,
             32'h007FFFFF, 32'h00800000, 32'h7F7FFFFF, 32'h7F800000, 32'h7FC00000,
             32'hFFFFFFFF, 32'h3FB504F3, 32'h3FB504F4, 32'h3F3504F3, 32'h3F3504F4,
             32'h40000000, 32'h3F000000, 32'h402DF854, 32'h3F7FFFFF, 32'h3F800001,
             32'h55555555, 32'hAAAAAAAA};
    foreach (pats[i]) send_beat(pats[i], 1'b0);
    finish_stream();
  endtask

  // back-to-back burst with the sink always ready
  task automatic test_full_rate();
    sink_idle_en = 1'b0;
    for (int i = 0; i < 200; i++) send_beat($urandom, 1'b0);
    finish_stream();
    sink_idle_en = 1'b1;
  endtask

  task automatic test_random();
    logic [31:0] x;
    for (int i = 0; i < 1700; i++) begin
      case ($urandom_range(0, 3))
        0:       x = $urandom;
        1:       x = {$urandom_range(0, 1) == 1, 8'd127, 23'($urandom)} ^ 32'(i[0]);
        2:       x = {1'($urandom), 8'($urandom_range(120, 134)), 23'($urandom)};
        default: x = {1'($urandom), 8'd126 + 8'($urandom_range(0, 1)),
                      SqrtMant + 23'($urandom_range(0, 4)) - 23'd2};
      endcase
      send_beat(x, i % 300 < 200);
    end
    finish_stream();
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_full_rate();
    test_random();
    while (log_queue.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
